/* hw/rtl/fpa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared opcodes, widths and the word that travels down the fixed-point ALU
// pipeline.
// ----------------------------------------------------------------------------
package fpa_pkg;

	// binary point position of the fixed-point format
	localparam int FRAC_BITS = 14;
	// scaled dividend width: 32-bit magnitude shifted up by the fraction
	localparam int DIV_W = 32 + FRAC_BITS;
	// number of divider cells, one quotient bit each
	localparam int NUM_CELLS = DIV_W;

	typedef enum logic [3:0] {
		CMD_ITOF       = 4'd0,
		CMD_FTOI_TRUNC = 4'd1,
		CMD_FTOI_ROUND = 4'd2,
		CMD_ADD        = 4'd3,
		CMD_SUB        = 4'd4,
		CMD_ADD_INT    = 4'd5,
		CMD_SUB_INT    = 4'd6,
		CMD_MUL        = 4'd7,
		CMD_MUL_INT    = 4'd8,
		CMD_DIV        = 4'd9,
		CMD_DIV_INT    = 4'd10
	} cmd_t;

	// which path produces the final result
	typedef enum logic [1:0] {
		SEL_DIRECT = 2'd0,
		SEL_MUL    = 2'd1,
		SEL_DIV    = 2'd2
	} res_sel_t;

	typedef struct packed {
		res_sel_t           sel;
		logic               neg;
		logic               dz;
		logic [DIV_W-1:0]   num;
		logic [31:0]        rem;
		logic [31:0]        dvs;
		logic [31:0]        direct;
		logic signed [63:0] prod;
	} word_t;

endpackage
`default_nettype wire

/* hw/rtl/fpa_pre.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_pre
// Input stage: decodes the opcode, does the simple operations and the
// 32x32 multiply, and sets up divider magnitudes.
// ----------------------------------------------------------------------------
module fpa_pre (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [3:0]     cmd,
	input  wire logic [31:0]    operand_a,
	input  wire logic [31:0]    operand_b,
	output logic                out_valid,
	output fpa_pkg::word_t      out_word,
	input  wire logic           out_ready
);
	import fpa_pkg::*;

	localparam logic signed [32:0] BIAS33 = 33'((64'd1 << FRAC_BITS) - 64'd1);
	localparam logic signed [32:0] HALF33 = 33'(64'd1 << (FRAC_BITS - 1));

	logic               valid_q;
	word_t              word_s1;
	word_t              word_d;
	logic signed [32:0] a33;
	logic signed [32:0] rnd;
	logic signed [32:0] trunc_in;
	logic signed [32:0] round_in;
	logic [31:0]        a_mag;
	logic [31:0]        b_mag;
	logic [31:0]        b_shift;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_word  = word_s1;

	// decode and simple arithmetic
	always_comb begin
		a33      = $signed({operand_a[31], operand_a});
		trunc_in = operand_a[31] ? (a33 + BIAS33) : a33;
		rnd      = operand_a[31] ? (a33 - HALF33) : (a33 + HALF33);
		round_in = rnd[32] ? (rnd + BIAS33) : rnd;
		a_mag    = operand_a[31] ? (~operand_a + 32'd1) : operand_a;
		b_mag    = operand_b[31] ? (~operand_b + 32'd1) : operand_b;
		b_shift  = operand_b << FRAC_BITS;

		word_d        = '0;
		word_d.sel    = SEL_DIRECT;
		word_d.neg    = operand_a[31] ^ operand_b[31];
		word_d.dvs    = b_mag;
		word_d.prod   = $signed(operand_a) * $signed(operand_b);
		case (cmd)
			CMD_ITOF:       word_d.direct = b_shift;
			CMD_FTOI_TRUNC: word_d.direct = 32'(trunc_in >>> FRAC_BITS);
			CMD_FTOI_ROUND: word_d.direct = 32'(round_in >>> FRAC_BITS);
			CMD_ADD:        word_d.direct = operand_a + operand_b;
			CMD_SUB:        word_d.direct = operand_a - operand_b;
			CMD_ADD_INT:    word_d.direct = operand_a + b_shift;
			CMD_SUB_INT:    word_d.direct = operand_a - b_shift;
			CMD_MUL:        word_d.sel = SEL_MUL;
			CMD_MUL_INT:    word_d.direct = word_d.prod[31:0];
			CMD_DIV: begin
				if (operand_b == 32'd0) begin
					word_d.dz = 1'b1;
				end else begin
					word_d.sel = SEL_DIV;
					word_d.num = {a_mag, {FRAC_BITS{1'b0}}};
				end
			end
			CMD_DIV_INT: begin
				if (operand_b == 32'd0) begin
					word_d.dz = 1'b1;
				end else begin
					word_d.sel = SEL_DIV;
					word_d.num = {{FRAC_BITS{1'b0}}, a_mag};
				end
			end
			default: word_d.direct = 32'd0;
		endcase
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= word_d;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/fpa_div_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_div_cell
// One restoring-division cell: shifts one dividend bit into the partial
// remainder and produces one quotient bit.
// ----------------------------------------------------------------------------
module fpa_div_cell (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire fpa_pkg::word_t in_word,
	output logic           out_valid,
	output fpa_pkg::word_t out_word,
	input  wire logic      out_ready
);
	import fpa_pkg::*;

	logic        valid_q;
	word_t       word_q;
	word_t       word_d;
	logic [32:0] rem_sh;
	logic [32:0] diff;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_word  = word_q;

	// trial subtract and quotient bit
	always_comb begin
		rem_sh = {in_word.rem, in_word.num[DIV_W-1]};
		diff   = rem_sh - {1'b0, in_word.dvs};
		word_d = in_word;
		if (!diff[32]) begin
			word_d.rem = diff[31:0];
		end else begin
			word_d.rem = rem_sh[31:0];
		end
		word_d.num = {in_word.num[DIV_W-2:0], ~diff[32]};
	end

	// cell valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// cell payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_q <= word_d;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/fpa_post.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_post
// Output stage: scales the product, signs the quotient and holds the
// result word for the consumer.
// ----------------------------------------------------------------------------
module fpa_post (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire fpa_pkg::word_t in_word,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      result,
	output logic             divide_by_zero
);
	import fpa_pkg::*;

	localparam logic signed [63:0] BIAS64 = 64'((64'd1 << FRAC_BITS) - 64'd1);

	logic               valid_q;
	logic [31:0]        res_d;
	logic signed [63:0] prod_adj;
	logic [31:0]        quo;

	assign in_ready  = !valid_q || !out_stall;
	assign out_valid = valid_q;

	// result select
	always_comb begin
		prod_adj = in_word.prod[63] ? (in_word.prod + BIAS64) : in_word.prod;
		quo      = in_word.num[31:0];
		case (in_word.sel)
			SEL_MUL: res_d = 32'(prod_adj >>> FRAC_BITS);
			SEL_DIV: res_d = in_word.neg ? (~quo + 32'd1) : quo;
			default: res_d = in_word.direct;
		endcase
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			result         <= res_d;
			divide_by_zero <= in_word.dz;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/fixed_point_alu_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// path: from accept to result a word passes the input stage, 46 divider cells and the
// output stage; every opcode takes the same path so order is kept
// throughput: one word per cycle unless out_stall holds the pipe, set by the chain of one-bit divider cells
// each stage advances when its successor frees, so bubbles close up
// reset: arst_n clears all valid flags; payload registers are not reset
// ----------------------------------------------------------------------------
// fixed_point_alu_top
// Signed 32-bit fixed-point ALU with a pipelined multiply and a chain of
// restoring-division cells.
// ----------------------------------------------------------------------------
module fixed_point_alu_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [3:0]  cmd,
	input  wire logic [31:0] operand_a,
	input  wire logic [31:0] operand_b,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      result,
	output logic             divide_by_zero
);
	import fpa_pkg::*;

	logic  in_ready;
	logic  valid_c [0:NUM_CELLS];
	logic  ready_c [0:NUM_CELLS];
	word_t word_c  [0:NUM_CELLS];

	assign in_stall = !in_ready;

	// decode and multiply
	fpa_pre u_pre (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.out_valid (valid_c[0]),
		.out_word  (word_c[0]),
		.out_ready (ready_c[0])
	);

	// divider cell chain
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		fpa_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[i]),
			.in_ready  (ready_c[i]),
			.in_word   (word_c[i]),
			.out_valid (valid_c[i+1]),
			.out_word  (word_c[i+1]),
			.out_ready (ready_c[i+1])
		);
	end

	// result stage
	fpa_post u_post (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (valid_c[NUM_CELLS]),
		.in_ready       (ready_c[NUM_CELLS]),
		.in_word        (word_c[NUM_CELLS]),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result         (result),
		.divide_by_zero (divide_by_zero)
	);

endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fixed-point ALU: a directed table of corner
// words followed by random words, every result checked against a local
// 17.14 arithmetic model, with random idling on both sides of the pipe.
// ----------------------------------------------------------------------------
module tb;
	import fpa_pkg::*;

	localparam int SCALE_SH = FRAC_BITS;
	localparam int N_RANDOM = 900;

	typedef struct {
		logic [3:0]  op;
		logic [31:0] a;
		logic [31:0] b;
		logic        known;
		logic [31:0] res;
		logic        dz;
	} vec_t;

	typedef struct {
		logic [31:0] res;
		logic        dz;
	} alu_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [3:0]  cmd = '0;
	logic [31:0] operand_a = '0;
	logic [31:0] operand_b = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] result;
	logic        divide_by_zero;

	alu_out_t pending_q[$];
	int       n_fail = 0;
	int       src_idle_pct = 20;
	int       snk_idle_pct = 70;

	fixed_point_alu_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .operand_a(operand_a), .operand_b(operand_b),
		.out_valid(out_valid), .out_stall(out_stall),
		.result(result), .divide_by_zero(divide_by_zero)
	);

	always #5 clk = ~clk;

	// truncating signed divide of wide values, d nonzero
	function automatic logic [63:0] trunc_div(logic signed [127:0] n, logic signed [127:0] d);
		logic [127:0] mn, md, q;
		mn = n < 0 ? -n : n;
		md = d < 0 ? -d : d;
		q = mn / md;
		return ((n < 0) != (d < 0)) ? 64'(-q) : q[63:0];
	endfunction

	// expected result of one ALU word
	function automatic alu_out_t alu_expect(logic [3:0] op, logic [31:0] ua, logic [31:0] ub);
		logic signed [127:0] a, b, half, scl;
		alu_out_t o;
		a = signed'(128'(signed'(ua)));
		b = signed'(128'(signed'(ub)));
		scl = 128'sd1 <<< SCALE_SH;
		half = scl / 2;
		o.res = '0;
		o.dz = 1'b0;
		case (op)
			CMD_ITOF: o.res = ub << SCALE_SH;
			CMD_FTOI_TRUNC: o.res = 32'(trunc_div(a, scl));
			CMD_FTOI_ROUND: o.res = 32'(trunc_div(a >= 0 ? a + half : a - half, scl));
			CMD_ADD: o.res = ua + ub;
			CMD_SUB: o.res = ua - ub;
			CMD_ADD_INT: o.res = ua + (ub << SCALE_SH);
			CMD_SUB_INT: o.res = ua - (ub << SCALE_SH);
			CMD_MUL: o.res = 32'(trunc_div(a * b, scl));
			CMD_MUL_INT: o.res = ua * ub;
			CMD_DIV: begin
				if (ub == 0) o.dz = 1'b1;
				else o.res = 32'(trunc_div(a * scl, b));
			end
			CMD_DIV_INT: begin
				if (ub == 0) o.dz = 1'b1;
				else o.res = 32'(trunc_div(a, b));
			end
			default: o.res = '0;
		endcase
		return o;
	endfunction

	// hand one word to the block, honoring stall
	task automatic send_word(logic [3:0] op, logic [31:0] a, logic [31:0] b, logic known,
			logic [31:0] r, logic z);
		alu_out_t o;
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		o = alu_expect(op, a, b);
		if (known) begin
			o.res = r;
			o.dz = z;
		end
		in_valid <= 1'b1;
		cmd <= op;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_q.push_back(o);
	endtask

	// receiver idling
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < snk_idle_pct);
	end

	// result checking
	always @(posedge clk) begin
		alu_out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				$error("result word with nothing pending: %h", result);
				n_fail++;
			end else begin
				e = pending_q.pop_front();
				if (result !== e.res) begin
					$error("result expected %h actual %h", e.res, result);
					n_fail++;
				end
				if (divide_by_zero !== e.dz) begin
					$error("divide_by_zero expected %b actual %b", e.dz, divide_by_zero);
					n_fail++;
				end
			end
		end
	end

	function automatic logic [31:0] rand_val();
		case ($urandom_range(5))
			0: return 32'h8000_0000 + $urandom_range(3);
			1: return 32'h7fff_ffff - $urandom_range(3);
			2: return 32'($signed($urandom_range(64)) - 32);
			3: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
			default: return $urandom;
		endcase
	endfunction

	initial begin
		vec_t dir[$];
		logic [3:0] op;
		logic [31:0] b;
		// corner words; known rows carry the obvious answer
		dir = '{
			'{CMD_ITOF, 32'h0, 32'h1, 1, 32'h4000, 0},
			'{CMD_ITOF, 32'h0, 32'hffff_ffff, 1, 32'hffff_c000, 0},
			'{CMD_FTOI_TRUNC, 32'h8000_0000, 32'h0, 1, 32'hfffe_0000, 0},
			'{CMD_FTOI_TRUNC, 32'hffff_ffff, 32'h0, 1, 32'h0, 0},
			'{CMD_FTOI_ROUND, 32'h7fff_ffff, 32'h0, 0, 0, 0},
			'{CMD_FTOI_ROUND, 32'hffff_e000, 32'h0, 1, 32'hffff_ffff, 0},
			'{CMD_FTOI_ROUND, 32'h8000_0000, 32'h0, 0, 0, 0},
			'{CMD_ADD, 32'h7fff_ffff, 32'h1, 1, 32'h8000_0000, 0},
			'{CMD_SUB, 32'h8000_0000, 32'h1, 1, 32'h7fff_ffff, 0},
			'{CMD_ADD_INT, 32'h1, 32'hffff_ffff, 0, 0, 0},
			'{CMD_SUB_INT, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0},
			'{CMD_MUL, 32'h8000_0000, 32'h8000_0000, 0, 0, 0},
			'{CMD_MUL, 32'h7fff_ffff, 32'hffff_ffff, 0, 0, 0},
			'{CMD_MUL_INT, 32'hffff_ffff, 32'hffff_ffff, 1, 32'h1, 0},
			'{CMD_DIV, 32'h1234_5678, 32'h0, 1, 32'h0, 1},
			'{CMD_DIV, 32'h8000_0000, 32'h1, 0, 0, 0},
			'{CMD_DIV, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0},
			'{CMD_DIV_INT, 32'hffff_ffff, 32'h0, 1, 32'h0, 1},
			'{CMD_DIV_INT, 32'h8000_0000, 32'hffff_ffff, 1, 32'h8000_0000, 0},
			'{CMD_DIV_INT, 32'hffff_fff9, 32'h2, 1, 32'hffff_fffd, 0},
			'{4'd11, 32'hffff_ffff, 32'h0, 1, 32'h0, 0},
			'{4'd15, 32'hffff_ffff, 32'h0, 1, 32'h0, 0}
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir[i])
			send_word(dir[i].op, dir[i].a, dir[i].b, dir[i].known, dir[i].res, dir[i].dz);
		// random words in three idling phases
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 3) begin
				src_idle_pct = 70;
				snk_idle_pct = 20;
			end else if (i == 2 * N_RANDOM / 3) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			op = ($urandom_range(15) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(10));
			b = ($urandom_range(15) == 0) ? 32'h0 : rand_val();
			send_word(op, rand_val(), b, 1'b0, '0, 1'b0);
		end
		in_valid <= 1'b0;
		snk_idle_pct = 0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (n_fail == 0)
			$display("[fixed_point_alu_top] OK");
		else
			$display("[fixed_point_alu_top] ERROR");
		$finish;
	end

	// run time limit
	initial begin
		#2ms;
		$display("[fixed_point_alu_top] ERROR");
		$finish;
	end

endmodule
